/* rtl/core/htt_pkg.sv */
// htt_pkg: shared types, codes and sizes for the hash translation table
// used by htt_cell and by the top level bidirectional_hash_translation_table
// no dependencies
`default_nettype none

package htt_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		KIND_ADD     = 3'd0,
		KIND_TO_RUN  = 3'd1,
		KIND_TO_CAN  = 3'd2,
		KIND_HAS_CAN = 3'd3,
		KIND_HAS_RUN = 3'd4,
		KIND_INVAL   = 3'd5,
		KIND_CLEAR   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ZERO       = 3'd1,
		ST_CANON_COLL = 3'd2,
		ST_RUN_COLL   = 3'd3,
		ST_FULL       = 3'd4,
		ST_MISS       = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] key_hash;
		logic [63:0] pair_hash;
		logic [63:0] build_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [63:0] result_hash;
		logic [8:0]  entry_count;
		logic [31:0] collision_total;
		logic [31:0] miss_total;
		logic [31:0] hit_total;
	} rsp_t;

	// query token walking the row of cells, with the running search results
	typedef struct packed {
		logic             valid;
		logic [2:0]       kind;
		logic [63:0]      key;
		logic [63:0]      probe;
		logic [63:0]      build;
		logic             c_hit;
		logic [63:0]      c_data;
		logic             r_hit;
		logic [63:0]      r_data;
		logic             free_hit;
		logic [IDX_W-1:0] free_idx;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] kill_cnt;
	} htt_tok_t;

	// commit broadcast from the controller to every cell
	typedef struct packed {
		logic        clear_all;
		logic [63:0] build;
		logic [63:0] canon;
		logic [63:0] runtime;
	} htt_wr_t;

endpackage

`default_nettype wire

/* rtl/core/htt_cell.sv */
// htt_cell: one table slot plus one stage of the query token chain
// depends on htt_pkg
`default_nettype none

module htt_cell import htt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire htt_tok_t tok_i,
	output htt_tok_t      tok_o,
	input  wire htt_wr_t  wr,
	input  wire logic     wr_sel
);

	logic        valid_q;
	logic [63:0] build_q;
	logic [63:0] canon_q;
	logic [63:0] runtime_q;
	logic        tok_vld_q;
	htt_tok_t    tok_q;
	htt_tok_t    tok_d;
	logic        same_build;
	logic        c_match;
	logic        r_match;
	logic        kill;

	always_comb begin
		same_build = valid_q && (build_q == tok_i.build);
		c_match    = same_build && (canon_q == tok_i.key);
		r_match    = same_build && (runtime_q == tok_i.probe);
		kill       = tok_i.valid && (tok_i.kind == KIND_INVAL) && same_build;
		tok_d      = tok_i;
		tok_d.pos  = tok_i.pos + IDX_W'(1);
		// lower slots were seen first, so only the first hit is kept
		if (!tok_i.c_hit && c_match) begin
			tok_d.c_hit  = 1'b1;
			tok_d.c_data = runtime_q;
		end
		if (!tok_i.r_hit && r_match) begin
			tok_d.r_hit  = 1'b1;
			tok_d.r_data = canon_q;
		end
		if (!tok_i.free_hit && !valid_q) begin
			tok_d.free_hit = 1'b1;
			tok_d.free_idx = tok_i.pos;
		end
		if (kill) begin
			tok_d.kill_cnt = tok_i.kill_cnt + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_i.valid;
			if (wr.clear_all) begin
				valid_q <= 1'b0;
			end else if (wr_sel) begin
				valid_q <= 1'b1;
			end else if (kill) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
		if (wr_sel) begin
			build_q   <= wr.build;
			canon_q   <= wr.canon;
			runtime_q <= wr.runtime;
		end
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = tok_vld_q;
	end

endmodule

`default_nettype wire

/* rtl/core/bidirectional_hash_translation_table.sv */
// a request passes the head register, each cell register and the tail register,
// and its result enters the output register once that register is free; only one
// operation is in the chain, as the query token walks the row of cells one slot per
// cycle before the add commit can be chosen; a new request is taken while the
// previous result still waits in the output register; reset: all slots invalid,
// counters zero, no clearing pass needed; depends on htt_pkg and htt_cell
`default_nettype none

module bidirectional_hash_translation_table import htt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// request transfer side
	logic     req_fire;
	logic     busy_q;
	logic     head_vld_q;
	htt_tok_t head_q;

	// chain taps: chain[i] feeds cell i, chain[TABLE_ENTRIES] leaves the row
	htt_tok_t chain [TABLE_ENTRIES+1];

	// token parked at the end of the row until its result can be loaded
	logic     tail_vld_q;
	htt_tok_t tail_q;
	logic     finish;

	// table-wide state kept in the controller
	logic [CNT_W-1:0] count_q;
	logic [31:0]      coll_q;
	logic [31:0]      miss_q;
	logic [31:0]      hit_q;

	// finish-step results
	logic [CNT_W-1:0]         count_d;
	logic [31:0]              coll_d;
	logic [31:0]              miss_d;
	logic [31:0]              hit_d;
	rsp_t                     rsp_d;
	logic                     add_write;
	logic                     clear_now;
	htt_wr_t                  wr;
	logic [TABLE_ENTRIES-1:0] wr_sel;

	// output register
	logic out_vld_q;
	rsp_t out_q;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// only one operation lives in the chain at a time
	assign req_stall = busy_q;
	assign req_fire  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			head_vld_q <= 1'b0;
		end else begin
			head_vld_q <= req_fire;
			if (req_fire) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	// launch token: adds probe the runtime column with the paired hash
	always_ff @(posedge clk) begin
		if (req_fire) begin
			head_q.valid    <= 1'b1;
			head_q.kind     <= req.kind;
			head_q.key      <= req.key_hash;
			head_q.probe    <= (req.kind == KIND_ADD) ? req.pair_hash : req.key_hash;
			head_q.build    <= req.build_id;
			head_q.c_hit    <= 1'b0;
			head_q.c_data   <= 64'd0;
			head_q.r_hit    <= 1'b0;
			head_q.r_data   <= 64'd0;
			head_q.free_hit <= 1'b0;
			head_q.free_idx <= '0;
			head_q.pos      <= '0;
			head_q.kill_cnt <= '0;
		end
	end

	always_comb begin
		chain[0]       = head_q;
		chain[0].valid = head_vld_q;
	end

	// the row of slot cells, slot 0 first so the lowest match wins
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		htt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[i]),
			.tok_o  (chain[i+1]),
			.wr     (wr),
			.wr_sel (wr_sel[i])
		);
	end

	// park the token that walked off the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_vld_q <= 1'b0;
		end else if (chain[TABLE_ENTRIES].valid) begin
			tail_vld_q <= 1'b1;
		end else if (finish) begin
			tail_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[TABLE_ENTRIES].valid) begin
			tail_q <= chain[TABLE_ENTRIES];
		end
	end

	// finish once the output register is free or being emptied this cycle
	assign finish = tail_vld_q && (!out_vld_q || !rsp_stall);

	// decide the operation outcome from the gathered search results
	always_comb begin
		count_d   = count_q;
		coll_d    = coll_q;
		miss_d    = miss_q;
		hit_d     = hit_q;
		add_write = 1'b0;
		clear_now = 1'b0;
		rsp_d     = '0;
		rsp_d.status = ST_OK;
		case (tail_q.kind)
			KIND_ADD: begin
				if (tail_q.key == 64'd0 || tail_q.probe == 64'd0) begin
					rsp_d.status = ST_ZERO;
				end else if (tail_q.c_hit && tail_q.c_data != tail_q.probe) begin
					rsp_d.status = ST_CANON_COLL;
					coll_d = sat_inc(coll_q);
				end else if (tail_q.r_hit && tail_q.r_data != tail_q.key) begin
					rsp_d.status = ST_RUN_COLL;
					coll_d = sat_inc(coll_q);
				end else if (tail_q.c_hit) begin
					// identical pair already present
					rsp_d.status = ST_OK;
				end else if (tail_q.free_hit) begin
					add_write = 1'b1;
					count_d   = count_q + CNT_W'(1);
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			KIND_TO_RUN: begin
				if (tail_q.c_hit) begin
					rsp_d.found       = 1'b1;
					rsp_d.result_hash = tail_q.c_data;
					hit_d             = sat_inc(hit_q);
				end else begin
					rsp_d.status = ST_MISS;
					miss_d       = sat_inc(miss_q);
				end
			end
			KIND_TO_CAN: begin
				if (tail_q.r_hit) begin
					rsp_d.found       = 1'b1;
					rsp_d.result_hash = tail_q.r_data;
					hit_d             = sat_inc(hit_q);
				end else begin
					rsp_d.status = ST_MISS;
					miss_d       = sat_inc(miss_q);
				end
			end
			KIND_HAS_CAN: begin
				rsp_d.found = tail_q.c_hit;
				if (!tail_q.c_hit) begin
					rsp_d.status = ST_MISS;
				end
			end
			KIND_HAS_RUN: begin
				rsp_d.found = tail_q.r_hit;
				if (!tail_q.r_hit) begin
					rsp_d.status = ST_MISS;
				end
			end
			KIND_INVAL: begin
				// the cells already dropped their slots as the token passed
				count_d = count_q - tail_q.kill_cnt;
			end
			KIND_CLEAR: begin
				clear_now = 1'b1;
				count_d   = '0;
				coll_d    = 32'd0;
				miss_d    = 32'd0;
				hit_d     = 32'd0;
			end
			default: begin
			end
		endcase
		rsp_d.entry_count     = 9'(count_d);
		rsp_d.collision_total = coll_d;
		rsp_d.miss_total      = miss_d;
		rsp_d.hit_total       = hit_d;
	end

	// commit broadcast: one-hot slot write for an add, or a full clear
	always_comb begin
		wr.clear_all = finish && clear_now;
		wr.build     = tail_q.build;
		wr.canon     = tail_q.key;
		wr.runtime   = tail_q.probe;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			wr_sel[i] = finish && add_write && (tail_q.free_idx == IDX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			coll_q    <= 32'd0;
			miss_q    <= 32'd0;
			hit_q     <= 32'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (finish) begin
				count_q   <= count_d;
				coll_q    <= coll_d;
				miss_q    <= miss_d;
				hit_q     <= hit_d;
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q <= rsp_d;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// a token leaving the row always belongs to an accepted, unfinished request
	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_ENTRIES].valid |-> busy_q)
		else $error("token left the row with no request in flight");

	// at most one slot is written per commit, and never together with a clear
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_sel) && !(wr.clear_all && (wr_sel != '0)))
		else $error("bad slot commit");

	// the entry count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count overflow");

	// a finished operation shows up as a result on the next cycle
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp_valid && !busy_q)
		else $error("finished operation not presented");

endmodule

`default_nettype wire
